// ===== rtl/frame_pacer_with_average_rate_top_defines.svh =====
// Assertion helpers shared by the pacer RTL.
`ifndef FRAME_PACER_WITH_AVERAGE_RATE_TOP_DEFINES_SVH
`define FRAME_PACER_WITH_AVERAGE_RATE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FPAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FPAR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/fpar_pkg.sv =====
package fpar_pkg;

    localparam int TIME_W     = 48;
    localparam int WORK_W     = 32;
    localparam int PERIOD_W   = 24;
    localparam int RATE_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 24'd16667;
    localparam logic [RATE_W-1:0]   TICK_RATE_RST    = 32'd1000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE    = 2'd1;

    // event kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

endpackage

// ===== rtl/fpar_ram.sv =====
module fpar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpar_div.sv =====
`include "frame_pacer_with_average_rate_top_defines.svh"

// Restoring divider, one quotient bit per cycle.
module fpar_div #(
    parameter int DW = 35
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DW-1:0]             i_dividend,
    input  logic [fpar_pkg::WORK_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_quotient
);

    localparam int VW    = fpar_pkg::WORK_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem,     n_rem;
    logic [DW-1:0]    r_quo,     n_quo;
    logic [VW-1:0]    r_divisor, n_divisor;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic             r_busy,    n_busy;
    logic             r_done,    n_done;
    logic [VW+1:0]    trial;
    logic             ge;

    always_comb begin
        trial     = {1'b0, r_rem, r_quo[DW-1]} - {2'b00, r_divisor};
        ge        = !trial[VW+1];
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_start) begin
            n_rem     = '0;
            n_quo     = i_dividend;
            n_divisor = i_divisor;
            n_cnt     = CNT_W'(DW);
            n_busy    = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? trial[VW-1:0] : {r_rem[VW-2:0], r_quo[DW-1]};
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `FPAR_ASSERT(a_no_restart, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `FPAR_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy, "done while still iterating")
    `FPAR_ASSERT(a_busy_cnt, i_clk, i_rst_n, r_busy |-> (r_cnt != '0), "busy with zero step count")

endmodule

// ===== rtl/frame_pacer_with_average_rate_top.sv =====
// Frame pacer with moving-average work time and frame rate.
// Input channel (i_in_valid / o_in_stall): one beat carries an event kind
// (i_op: 0 frame start, 1 frame end) and the current timestamp i_now_time.
// Output channel (o_out_valid / i_out_stall): exactly one result beat per
// input beat, in order: wait ticks, work ticks, average work, frame rate,
// resync flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// frame period, index 1 the tick rate; other indexes are dropped.
// A start event goes from accept straight to the output load. An end event
// makes two passes through the shared one-bit-per-cycle divider, average
// first and then the rate, with sum update, resync check, two done handoffs,
// rate setup and the output load around them. A zero average skips the rate
// pass. One event is in flight at a time, so a new beat waits until the last
// one is through; the next beat is taken in the cycle after the result loads.
// Results sit in an output register; while the receiver stalls, the next
// event is still accepted and worked on, and its result waits until the
// register frees. Reset restores the default period and tick rate and clears
// deadline, frame start, sum, fill count and pointer; history entries are
// only read once written, so the history memory has no clearing pass.
`include "frame_pacer_with_average_rate_top_defines.svh"

module frame_pacer_with_average_rate_top #(
    parameter int WINDOW_DEPTH = fpar_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [fpar_pkg::TIME_W-1:0]       i_now_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fpar_pkg::TIME_W-1:0]       o_wait_ticks,
    output logic [fpar_pkg::WORK_W-1:0]       o_work_ticks,
    output logic [fpar_pkg::WORK_W-1:0]       o_average_work,
    output logic [fpar_pkg::RATE_W-1:0]       o_frame_rate,
    output logic                              o_resynced,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpar_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TW    = fpar_pkg::TIME_W;
    localparam int WW    = fpar_pkg::WORK_W;
    localparam int PW    = fpar_pkg::PERIOD_W;
    localparam int RW    = fpar_pkg::RATE_W;
    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = WW + $clog2(WINDOW_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_AVG   = 3'd2;
    localparam logic [2:0] ST_AVGW  = 3'd3;
    localparam logic [2:0] ST_RATE  = 3'd4;
    localparam logic [2:0] ST_RATEW = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]       r_state,    n_state;
    logic [PW-1:0]    r_period,   n_period;
    logic [RW-1:0]    r_tick,     n_tick;
    logic [TW-1:0]    r_deadline, n_deadline;
    logic [TW-1:0]    r_fstart,   n_fstart;
    logic [PTR_W-1:0] r_ptr,      n_ptr;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [SUM_W-1:0] r_sum,      n_sum;
    logic [WW-1:0]    r_avg,      n_avg;
    logic [RW-1:0]    r_rate,     n_rate;
    logic [TW-1:0]    r_now,      n_now;
    logic [TW-1:0]    r_wait,     n_wait;
    logic [WW-1:0]    r_work,     n_work;
    logic             r_resync,   n_resync;
    logic             r_ov,       n_ov;
    logic [TW-1:0]    r_o_wait,   n_o_wait;
    logic [WW-1:0]    r_o_work,   n_o_work;
    logic [WW-1:0]    r_o_avg,    n_o_avg;
    logic [RW-1:0]    r_o_rate,   n_o_rate;
    logic             r_o_resync, n_o_resync;

    logic             in_acc;
    logic             full;
    logic [TW-1:0]    diff;
    logic [WW-1:0]    hist_rdata;
    logic             hist_we;
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [WW-1:0]    div_divisor;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign full        = (r_count == CNT_W'(WINDOW_DEPTH));
    assign hist_we     = (r_state == ST_UPD);

    fpar_ram #(
        .WIDTH (WW),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(PTR_W)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(r_ptr),
        .i_wdata(r_work),
        .i_raddr(r_ptr),
        .o_rdata(hist_rdata)
    );

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_sum;
        div_divisor  = WW'(r_count);
        case (r_state)
            ST_AVG: begin
                div_start = 1'b1;
            end
            ST_RATE: begin
                div_start    = (r_avg != '0);
                div_dividend = SUM_W'(r_tick);
                div_divisor  = r_avg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    fpar_div #(
        .DW(SUM_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    always_comb begin
        n_state    = r_state;
        n_period   = r_period;
        n_tick     = r_tick;
        n_deadline = r_deadline;
        n_fstart   = r_fstart;
        n_ptr      = r_ptr;
        n_count    = r_count;
        n_sum      = r_sum;
        n_avg      = r_avg;
        n_rate     = r_rate;
        n_now      = r_now;
        n_wait     = r_wait;
        n_work     = r_work;
        n_resync   = r_resync;
        n_ov       = r_ov && i_out_stall;
        n_o_wait   = r_o_wait;
        n_o_work   = r_o_work;
        n_o_avg    = r_o_avg;
        n_o_rate   = r_o_rate;
        n_o_resync = r_o_resync;
        diff       = i_now_time - r_fstart;

        if (i_cfg_valid) begin
            if (i_cfg_index == fpar_pkg::CFG_FRAME_PERIOD) begin
                n_period = i_cfg_data[PW-1:0];
            end else if (i_cfg_index == fpar_pkg::CFG_TICK_RATE) begin
                n_tick = i_cfg_data[RW-1:0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_now    = i_now_time;
                    n_resync = 1'b0;
                    if (i_op == fpar_pkg::OP_START) begin
                        n_work = '0;
                        if (r_deadline > i_now_time) begin
                            n_wait   = r_deadline - i_now_time;
                            n_fstart = r_deadline;
                        end else begin
                            n_wait   = '0;
                            n_fstart = i_now_time;
                        end
                        n_state = ST_OUT;
                    end else begin
                        n_wait = '0;
                        // end before start counts as zero work
                        if (i_now_time <= r_fstart) begin
                            n_work = '0;
                        end else if (diff[TW-1:WW] != '0) begin
                            n_work = '1;
                        end else begin
                            n_work = diff[WW-1:0];
                        end
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                // the slot's old value drops out once the window is full
                n_sum = r_sum - (full ? SUM_W'(hist_rdata) : '0) + SUM_W'(r_work);
                n_ptr = (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
                if (!full) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_deadline = r_deadline + TW'(r_period);
                n_state    = ST_AVG;
            end
            ST_AVG: begin
                if (r_deadline < r_now) begin
                    n_deadline = r_now + TW'(r_period);
                    n_resync   = 1'b1;
                end
                n_state = ST_AVGW;
            end
            ST_AVGW: begin
                if (div_done) begin
                    n_avg   = div_quo[WW-1:0];
                    n_state = ST_RATE;
                end
            end
            ST_RATE: begin
                if (r_avg == '0) begin
                    n_rate  = '0;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RATEW;
                end
            end
            ST_RATEW: begin
                if (div_done) begin
                    n_rate  = div_quo[RW-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov       = 1'b1;
                    n_o_wait   = r_wait;
                    n_o_work   = r_work;
                    n_o_avg    = r_avg;
                    n_o_rate   = r_rate;
                    n_o_resync = r_resync;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_period   <= fpar_pkg::FRAME_PERIOD_RST;
            r_tick     <= fpar_pkg::TICK_RATE_RST;
            r_deadline <= '0;
            r_fstart   <= '0;
            r_ptr      <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_avg      <= '0;
            r_rate     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_period   <= n_period;
            r_tick     <= n_tick;
            r_deadline <= n_deadline;
            r_fstart   <= n_fstart;
            r_ptr      <= n_ptr;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_avg      <= n_avg;
            r_rate     <= n_rate;
            r_ov       <= n_ov;
        end
        r_now      <= n_now;
        r_wait     <= n_wait;
        r_work     <= n_work;
        r_resync   <= n_resync;
        r_o_wait   <= n_o_wait;
        r_o_work   <= n_o_work;
        r_o_avg    <= n_o_avg;
        r_o_rate   <= n_o_rate;
        r_o_resync <= n_o_resync;
    end

    assign o_out_valid    = r_ov;
    assign o_wait_ticks   = r_o_wait;
    assign o_work_ticks   = r_o_work;
    assign o_average_work = r_o_avg;
    assign o_frame_rate   = r_o_rate;
    assign o_resynced     = r_o_resync;

    `FPAR_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(WINDOW_DEPTH), "count overflow")
    `FPAR_ASSERT(a_ptr_fill, i_clk, i_rst_n, !full |-> (CNT_W'(r_ptr) == r_count), "ptr/count skew")
    `FPAR_ASSERT(a_div_state, i_clk, i_rst_n, div_done |-> (r_state == ST_AVGW || r_state == ST_RATEW), "stray done")
    `FPAR_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, in_acc, o_in_stall, "no stall after an accepted beat")

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W     = fpar_pkg::TIME_W;
    localparam int WORK_W     = fpar_pkg::WORK_W;
    localparam int RATE_W     = fpar_pkg::RATE_W;
    localparam int PERIOD_W   = fpar_pkg::PERIOD_W;
    localparam int CFG_IDX_W  = fpar_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = fpar_pkg::CFG_DATA_W;

    localparam logic [PERIOD_W-1:0]  FRAME_PERIOD_RST = fpar_pkg::FRAME_PERIOD_RST;
    localparam logic [RATE_W-1:0]    TICK_RATE_RST    = fpar_pkg::TICK_RATE_RST;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = fpar_pkg::CFG_FRAME_PERIOD;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE    = fpar_pkg::CFG_TICK_RATE;
    localparam logic                 OP_START         = fpar_pkg::OP_START;
    localparam logic                 OP_END           = fpar_pkg::OP_END;

    localparam int          WINDOW    = fpar_pkg::WINDOW_DEPTH_DEF;
    localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] WORK_MAX  = 32'hFFFF_FFFF;
    localparam int          HOLD_AT   = 600;
    localparam int          HOLD_LEN  = 400;
    localparam int          TAIL_WAIT = 100;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct {
        logic              op;
        logic [TIME_W-1:0] stamp;
    } t_pacer_event;

    typedef struct packed {
        logic [TIME_W-1:0] wait_ticks;
        logic [WORK_W-1:0] work_ticks;
        logic [WORK_W-1:0] average_work;
        logic [RATE_W-1:0] frame_rate;
        logic              resynced;
    } t_pacer_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_op        = OP_START;
    logic [TIME_W-1:0]     i_now_time  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TIME_W-1:0]     o_wait_ticks;
    logic [WORK_W-1:0]     o_work_ticks;
    logic [WORK_W-1:0]     o_average_work;
    logic [RATE_W-1:0]     o_frame_rate;
    logic                  o_resynced;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    frame_pacer_with_average_rate_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wait_ticks   (o_wait_ticks),
        .o_work_ticks   (o_work_ticks),
        .o_average_work (o_average_work),
        .o_frame_rate   (o_frame_rate),
        .o_resynced     (o_resynced),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------- pacer prediction ----------------
    logic [PERIOD_W-1:0] cfg_period    = FRAME_PERIOD_RST;
    logic [RATE_W-1:0]   cfg_tick_rate = TICK_RATE_RST;

    logic [TIME_W-1:0]   next_due      = '0;
    logic [TIME_W-1:0]   start_mark    = '0;
    logic [WORK_W-1:0]   work_ring [WINDOW];
    logic [2:0]          ring_ptr      = '0;
    logic [3:0]          ring_fill     = '0;
    logic [34:0]         ring_sum      = '0;
    logic [WORK_W-1:0]   held_average  = '0;
    logic [RATE_W-1:0]   held_rate     = '0;

    function automatic t_pacer_result pace_event(input logic op, input logic [TIME_W-1:0] now);
        t_pacer_result     res;
        logic [TIME_W-1:0] span;
        logic [34:0]       mean;
        res = '0;
        if (op == OP_START) begin
            if (next_due > now) begin
                res.wait_ticks = next_due - now;
                start_mark     = next_due;
            end else begin
                start_mark = now;
            end
        end else begin
            span = (now > start_mark) ? now - start_mark : '0;
            res.work_ticks = (span > {16'd0, WORK_MAX}) ? WORK_MAX : span[WORK_W-1:0];
            if (ring_fill >= WINDOW)
                ring_sum = ring_sum - {3'd0, work_ring[ring_ptr]};
            work_ring[ring_ptr] = res.work_ticks;
            ring_sum = ring_sum + {3'd0, res.work_ticks};
            ring_ptr = ring_ptr + 3'd1;
            if (ring_fill < WINDOW)
                ring_fill = ring_fill + 4'd1;
            mean = ring_sum / {31'd0, ring_fill};
            held_average = mean[WORK_W-1:0];
            held_rate = (held_average != 0) ? cfg_tick_rate / held_average : '0;
            next_due = next_due + {24'd0, cfg_period};
            if (next_due < now) begin
                next_due     = now + {24'd0, cfg_period};
                res.resynced = 1'b1;
            end
        end
        res.average_work = held_average;
        res.frame_rate   = held_rate;
        return res;
    endfunction

    // ---------------- stimulus store ----------------
    t_pacer_event  pending_events[$];
    t_pacer_result due_results[$];
    int            queued_total   = 0;
    int            accepted_total = 0;
    int            results_seen   = 0;
    int            fail_count     = 0;
    logic [TIME_W-1:0] stim_clock = '0;

    function automatic logic [TIME_W-1:0] rand48();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom();
        lo = $urandom();
        return {hi[15:0], lo};
    endfunction

    task automatic queue_event(input logic op, input logic [TIME_W-1:0] stamp);
        t_pacer_event ev;
        ev.op    = op;
        ev.stamp = stamp;
        pending_events.insert(pending_events.size(), ev);
        queued_total++;
    endtask

    function automatic logic [TIME_W-1:0] frame_work(input int unsigned span);
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            7:       return {16'd0, r};
            8:       return rand48() >> 8;
            9:       return {16'd0, span};
            default: return {16'd0, 32'($urandom_range(0, span * 2))};
        endcase
    endfunction

    // mostly start/end pairs on a running clock; some noise, broken pairs and jumps
    task automatic add_random_events(input int count);
        int          added;
        int unsigned span;
        logic [47:0] hop;
        added = 0;
        span  = (cfg_period == 0) ? 1000 : cfg_period;
        while (added < count) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    queue_event(logic'($urandom_range(0, 1)), rand48());
                    added++;
                end
                2: begin
                    hop = {16'd0, 32'($urandom_range(0, span * 2))};
                    case ($urandom_range(0, 2))
                        0: begin
                            queue_event(OP_START, stim_clock);
                            queue_event(OP_START, stim_clock + hop);
                        end
                        1: begin
                            queue_event(OP_END, stim_clock);
                            queue_event(OP_END, stim_clock + hop);
                        end
                        default: begin
                            // end stamped before its start
                            queue_event(OP_START, stim_clock + hop + 48'd1);
                            queue_event(OP_END, stim_clock);
                        end
                    endcase
                    stim_clock = stim_clock + hop;
                    added += 2;
                end
                3: begin
                    if ($urandom_range(0, 1) != 0)
                        stim_clock = rand48();
                    else
                        stim_clock = TIME_MAX - {16'd0, 32'($urandom_range(0, span * 4))};
                end
                default: begin
                    stim_clock = stim_clock + {16'd0, 32'($urandom_range(0, span * 2))};
                    queue_event(OP_START, stim_clock);
                    stim_clock = stim_clock + frame_work(span);
                    queue_event(OP_END, stim_clock);
                    added += 2;
                end
            endcase
        end
    endtask

    task automatic drain();
        while (!(accepted_total == queued_total && due_results.size() == 0))
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FRAME_PERIOD)
            cfg_period = data[PERIOD_W-1:0];
        else if (idx == CFG_TICK_RATE)
            cfg_tick_rate = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------- input driver ----------------
    logic in_took    = 1'b0;
    int   burst_left = 0;
    int   gap_left   = 0;

    always @(negedge i_clk) begin
        t_pacer_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                ev = pending_events[0];
                pending_events.delete(0);
                i_in_valid <= 1'b1;
                i_op       <= ev.op;
                i_now_time <= ev.stamp;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 4);
                        2:       gap_left = $urandom_range(5, 40);
                        default: gap_left = $urandom_range(40, 120);
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- result stall pattern ----------------
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int stall_mode = 0;
    int stall_seg  = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_seg == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_seg  = $urandom_range(5, 60);
            end
            stall_seg--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------- monitor ----------------
    t_pacer_result want;

    task automatic check_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                due_results.insert(due_results.size(), pace_event(i_op, i_now_time));
                accepted_total++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result beat with nothing pending");
                    fail_count++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("wait_ticks", want.wait_ticks, o_wait_ticks);
                    check_field("work_ticks", {16'd0, want.work_ticks}, {16'd0, o_work_ticks});
                    check_field("average_work", {16'd0, want.average_work},
                                {16'd0, o_average_work});
                    check_field("frame_rate", {16'd0, want.frame_rate}, {16'd0, o_frame_rate});
                    check_field("resynced", {47'd0, want.resynced}, {47'd0, o_resynced});
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        logic [PERIOD_W-1:0] period;
        logic [RATE_W-1:0]   rate;
        logic [7:0]          junk;
        int                  t;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration
        queue_event(OP_END, 48'd0);                 // end with empty history: average 0
        queue_event(OP_START, 48'd100);             // deadline ahead
        queue_event(OP_END, 48'd10000);             // end before frame start
        queue_event(OP_START, 48'd20000);
        queue_event(OP_END, 48'd40000);
        queue_event(OP_START, TIME_MAX);            // deadline passed
        queue_event(OP_END, TIME_MAX);              // resync wraps past 2^48
        queue_event(OP_START, 48'd0);
        queue_event(OP_END, 48'h100_0000_0000);     // long work saturates
        queue_event(OP_START, 48'd1);
        queue_event(OP_END, TIME_MAX - 48'd16672);  // deadline lands just under the top
        queue_event(OP_START, 48'd10);              // near-full-range wait
        queue_event(OP_END, 48'd20);                // deadline advance wraps
        t = 100000;
        repeat (4) begin
            queue_event(OP_START, 48'(t));
            queue_event(OP_END, 48'(t + 5000));
            t += 16667;
        end
        drain();

        stim_clock = 48'd200000;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    period = '0;
                    rate   = '0;
                end
                1: begin
                    period = 24'd1;
                    rate   = 32'd1;
                end
                2: begin
                    period = '1;
                    rate   = '1;
                end
                3: begin
                    period = FRAME_PERIOD_RST;
                    rate   = TICK_RATE_RST;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       period = 24'($urandom_range(1, 100));
                        1:       period = 24'($urandom_range(100, 20000));
                        default: period = 24'($urandom_range(20000, 24'hFFFFFF));
                    endcase
                    rate = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(1, 5000);
                end
            endcase
            junk = 8'($urandom());
            if ($urandom_range(0, 1) != 0) begin
                write_reg(CFG_FRAME_PERIOD, {junk, period});
                write_reg(CFG_TICK_RATE, rate);
            end else begin
                write_reg(CFG_TICK_RATE, rate);
                write_reg(CFG_FRAME_PERIOD, {junk, period});
            end
            if (ph == 0 || $urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED_A, $urandom());
                write_reg(CFG_UNUSED_B, $urandom());
            end
            add_random_events(210);
            drain();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
